// ===== hw/rtl/rop_pkg.sv =====
// Shared constants of the ray orthogonal projector.
`default_nettype none
package rop_pkg;
  localparam int RAY_BITS_DEF        = 16;
  localparam int ENTRY_FRAC_BITS_DEF = 15;
  localparam int IDX_BITS            = 16;
  localparam int CFG_DATA_BITS       = 32;
  localparam int CFG_ADDR_BITS       = 4;
  localparam int NUM_QUOT            = 6;

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_ORIGIN_X = 4'h0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_ORIGIN_Y = 4'h4;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_ORIGIN_Z = 4'h8;
endpackage : rop_pkg
`default_nettype wire

// ===== hw/rtl/rop_div_cell.sv =====
// One restoring step of the fractional divider, applied to all six quotients.
`default_nettype none
module rop_div_cell import rop_pkg::*; #(
  parameter int SW = 33,
  parameter int QW = 16,
  parameter int NQ = NUM_QUOT,
  parameter int PW = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   vld_in,
  input  wire logic [SW-1:0]          den_in,
  input  wire logic [NQ-1:0][SW-1:0]  rem_in,
  input  wire logic [NQ-1:0][QW-1:0]  quo_in,
  input  wire logic [PW-1:0]          pass_in,
  output logic                        vld_out,
  output logic [SW-1:0]               den_out,
  output logic [NQ-1:0][SW-1:0]       rem_out,
  output logic [NQ-1:0][QW-1:0]       quo_out,
  output logic [PW-1:0]               pass_out
);
  logic [NQ-1:0][SW-1:0] rem_nxt;
  logic [NQ-1:0]         bit_nxt;
  logic                  vld_r;
  logic [SW-1:0]         den_r;
  logic [NQ-1:0][SW-1:0] rem_r;
  logic [NQ-1:0][QW-1:0] quo_r;
  logic [PW-1:0]         pass_r;

  // Remainder stays below den, so r >= den - r is the doubled compare without growth.
  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      bit_nxt[i] = (rem_in[i] >= (den_in - rem_in[i]));
      rem_nxt[i] = bit_nxt[i] ? (rem_in[i] - (den_in - rem_in[i])) : (rem_in[i] + rem_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    den_r  <= den_in;
    pass_r <= pass_in;
    for (int i = 0; i < NQ; i++) begin
      rem_r[i] <= rem_nxt[i];
      quo_r[i] <= {quo_in[i][QW-2:0], bit_nxt[i]};
    end
  end

  assign vld_out  = vld_r;
  assign den_out  = den_r;
  assign rem_out  = rem_r;
  assign quo_out  = quo_r;
  assign pass_out = pass_r;
endmodule : rop_div_cell
`default_nettype wire

// ===== hw/rtl/ray_orthogonal_projector_top.sv =====
// Top level of the ray orthogonal projector.
//
//  channel   ports                                   handshake
//  input     in_point_index, in_ray_x/y/z            start & !busy
//  result    out_block_index, out_p_*, out_rhs_*     out_valid strobe, one cycle
//  config    psel penable pwrite paddr pwdata        APB, pready tied high
//
// One ray is accepted every cycle; busy is always low. Each beat passes through
// the magnitude stage, the product stage, which also yields the squared length,
// a chain of ENTRY_FRAC_BITS divider cells that produce one quotient bit each,
// and then the rounding, rhs product, row sum and final round and saturate
// stages, each of them a register, before it leaves as a result.
// Reset is synchronous on rst_n and clears all valid flags and the origin.
// The receiver cannot stall; results stream out at the input rate.
// Origin registers must only be written while no beat is in flight.
`default_nettype none
module ray_orthogonal_projector_top import rop_pkg::*; #(
  parameter int RAY_BITS        = RAY_BITS_DEF,
  parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [IDX_BITS-1:0]          in_point_index,
  input  wire logic signed [RAY_BITS-1:0]   in_ray_x,
  input  wire logic signed [RAY_BITS-1:0]   in_ray_y,
  input  wire logic signed [RAY_BITS-1:0]   in_ray_z,
  output logic                              out_valid,
  output logic [IDX_BITS-1:0]               out_block_index,
  output logic [ENTRY_FRAC_BITS-1:0]        out_p_xx,
  output logic signed [ENTRY_FRAC_BITS:0]   out_p_xy,
  output logic signed [ENTRY_FRAC_BITS:0]   out_p_xz,
  output logic [ENTRY_FRAC_BITS-1:0]        out_p_yy,
  output logic signed [ENTRY_FRAC_BITS:0]   out_p_yz,
  output logic [ENTRY_FRAC_BITS-1:0]        out_p_zz,
  output logic signed [31:0]                out_rhs_x,
  output logic signed [31:0]                out_rhs_y,
  output logic signed [31:0]                out_rhs_z,
  output logic                              out_zero_ray,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]     paddr,
  input  wire logic [CFG_DATA_BITS-1:0]     pwdata,
  output logic [CFG_DATA_BITS-1:0]          prdata,
  output logic                              pready
);
  localparam int F   = ENTRY_FRAC_BITS;
  localparam int MW  = RAY_BITS;              // magnitude width
  localparam int PRW = 2 * MW;                // product width
  localparam int SW  = PRW + 2;               // sum of three squares
  localparam int QW  = F + 2;                 // quotient plus leading bit
  localparam int EW  = F + 2;                 // signed entry, holds +-2^F
  localparam int NQ  = NUM_QUOT;
  localparam int PW  = IDX_BITS + 4;          // index, zero flag, three signs
  localparam int AW  = 32 + EW + 2;           // rhs accumulator

  // Configuration registers.
  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic               cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_ORIGIN_X: org_x_r <= pwdata;
        ADDR_ORIGIN_Y: org_y_r <= pwdata;
        ADDR_ORIGIN_Z: org_z_r <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      ADDR_ORIGIN_X: prdata = org_x_r;
      ADDR_ORIGIN_Y: prdata = org_y_r;
      ADDR_ORIGIN_Z: prdata = org_z_r;
      default:       prdata = '0;
    endcase
  end

  assign busy = 1'b0;
  logic acc_in;
  assign acc_in = start && !busy;

  // Stage 1: magnitudes and signs.
  logic          s1_vld_r;
  logic [IDX_BITS-1:0] s1_idx_r;
  logic [MW-1:0] s1_mx_r, s1_my_r, s1_mz_r;
  logic          s1_nx_r, s1_ny_r, s1_nz_r;
  function automatic logic [MW-1:0] mag_f(input logic signed [MW-1:0] v);
    mag_f = v[MW-1] ? (~v + 1'b1) : v;
  endfunction
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= acc_in;
    s1_idx_r <= in_point_index;
    s1_mx_r  <= mag_f(in_ray_x);
    s1_my_r  <= mag_f(in_ray_y);
    s1_mz_r  <= mag_f(in_ray_z);
    s1_nx_r  <= in_ray_x[MW-1];
    s1_ny_r  <= in_ray_y[MW-1];
    s1_nz_r  <= in_ray_z[MW-1];
  end

  // Stage 2: six products and the squared length.
  logic              s2_vld_r;
  logic [PW-1:0]     s2_pass_r;
  logic [NQ-1:0][PRW-1:0] s2_prod_r;
  logic [SW-1:0]     s2_s_r;
  logic [NQ-1:0][PRW-1:0] prod_nxt;
  always_comb begin
    prod_nxt[0] = s1_mx_r * s1_mx_r;
    prod_nxt[1] = s1_my_r * s1_my_r;
    prod_nxt[2] = s1_mz_r * s1_mz_r;
    prod_nxt[3] = s1_mx_r * s1_my_r;
    prod_nxt[4] = s1_mx_r * s1_mz_r;
    prod_nxt[5] = s1_my_r * s1_mz_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_prod_r <= prod_nxt;
    s2_pass_r <= {s1_idx_r, 1'b0, s1_nx_r ^ s1_ny_r, s1_nx_r ^ s1_nz_r,
                  s1_ny_r ^ s1_nz_r};
  end
  assign s2_s_r = {2'b00, s2_prod_r[0]} + {2'b00, s2_prod_r[1]} + {2'b00, s2_prod_r[2]};

  // Divider setup: integer bit and starting remainder, zero ray forced to s = 1.
  logic              zero_w;
  logic [SW-1:0]     den_w;
  logic [NQ-1:0][SW-1:0] rem0_w;
  logic [NQ-1:0][QW-1:0] quo0_w;
  logic [PW-1:0]     pass0_w;
  always_comb begin
    zero_w = (s2_s_r == '0);
    den_w  = zero_w ? SW'(1) : s2_s_r;
    for (int i = 0; i < NQ; i++) begin
      logic [SW-1:0] n;
      n = zero_w ? '0 : {2'b00, s2_prod_r[i]};
      quo0_w[i] = QW'(n >= den_w);
      rem0_w[i] = (n >= den_w) ? (n - den_w) : n;
    end
    pass0_w = s2_pass_r;
    pass0_w[3] = zero_w;
  end

  // Chain of divider cells, one quotient bit per cell.
  logic [F:0]                  ch_vld;
  logic [F:0][SW-1:0]          ch_den;
  logic [F:0][NQ-1:0][SW-1:0]  ch_rem;
  logic [F:0][NQ-1:0][QW-1:0]  ch_quo;
  logic [F:0][PW-1:0]          ch_pass;
  assign ch_vld[0]  = s2_vld_r;
  assign ch_den[0]  = den_w;
  assign ch_rem[0]  = rem0_w;
  assign ch_quo[0]  = quo0_w;
  assign ch_pass[0] = pass0_w;
  for (genvar g = 0; g < F; g++) begin : g_cell
    rop_div_cell #(.SW(SW), .QW(QW), .NQ(NQ), .PW(PW)) u_cell (
      .clk, .rst_n,
      .vld_in(ch_vld[g]), .den_in(ch_den[g]), .rem_in(ch_rem[g]),
      .quo_in(ch_quo[g]), .pass_in(ch_pass[g]),
      .vld_out(ch_vld[g+1]), .den_out(ch_den[g+1]), .rem_out(ch_rem[g+1]),
      .quo_out(ch_quo[g+1]), .pass_out(ch_pass[g+1])
    );
  end

  // Rounding stage: final rounding bit, signed entries.
  logic                         r_vld_r;
  logic [PW-1:0]                r_pass_r;
  logic [NQ-1:0][EW-1:0]        r_ent_r;   // xx yy zz xy xz yz, signed
  logic [NQ-1:0][EW-1:0]        ent_nxt;
  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      logic [EW-1:0] q;
      q = EW'(ch_quo[F][i]) +
          EW'(ch_rem[F][i] >= (ch_den[F] - ch_rem[F][i]));
      if (i < 3) ent_nxt[i] = (EW'(1) << F) - q;
      else       ent_nxt[i] = ch_pass[F][5-i] ? q : (~q + 1'b1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) r_vld_r <= 1'b0;
    else        r_vld_r <= ch_vld[F];
    r_pass_r <= ch_pass[F];
    r_ent_r  <= ent_nxt;
  end

  // Rhs products: nine of them, one per multiplier.
  logic                      m_vld_r;
  logic [PW-1:0]             m_pass_r;
  logic [NQ-1:0][EW-1:0]     m_ent_r;
  logic signed [8:0][EW+31:0] m_prd_r;
  function automatic logic signed [EW+31:0] mul_f(input logic [EW-1:0] p,
                                                  input logic signed [31:0] c);
    mul_f = $signed(p) * c;
  endfunction
  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else        m_vld_r <= r_vld_r;
    m_pass_r <= r_pass_r;
    m_ent_r  <= r_ent_r;
    m_prd_r[0] <= mul_f(r_ent_r[0], org_x_r);
    m_prd_r[1] <= mul_f(r_ent_r[3], org_y_r);
    m_prd_r[2] <= mul_f(r_ent_r[4], org_z_r);
    m_prd_r[3] <= mul_f(r_ent_r[3], org_x_r);
    m_prd_r[4] <= mul_f(r_ent_r[1], org_y_r);
    m_prd_r[5] <= mul_f(r_ent_r[5], org_z_r);
    m_prd_r[6] <= mul_f(r_ent_r[4], org_x_r);
    m_prd_r[7] <= mul_f(r_ent_r[5], org_y_r);
    m_prd_r[8] <= mul_f(r_ent_r[2], org_z_r);
  end

  // Row sums. Elements of a packed array read as unsigned, so each product
  // is made signed again before it is widened.
  logic                  a_vld_r;
  logic [PW-1:0]         a_pass_r;
  logic [NQ-1:0][EW-1:0] a_ent_r;
  logic signed [2:0][AW-1:0] a_sum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= m_vld_r;
    a_pass_r <= m_pass_r;
    a_ent_r  <= m_ent_r;
    for (int k = 0; k < 3; k++) begin
      a_sum_r[k] <= AW'($signed(m_prd_r[3*k])) + AW'($signed(m_prd_r[3*k+1])) +
                    AW'($signed(m_prd_r[3*k+2]));
    end
  end

  // Output stage: round half away from zero, saturate.
  function automatic logic [31:0] rnd_sat(input logic signed [AW-1:0] a);
    logic [AW-1:0] m;
    logic [AW-1:0] rm;
    logic          neg;
    neg = a[AW-1];
    m   = neg ? (~a + 1'b1) : a;
    rm  = (m + (AW'(1) << (F - 1))) >> F;
    if (neg) rnd_sat = (rm > AW'(33'h080000000)) ? 32'h80000000 : 32'(~rm + 1'b1);
    else     rnd_sat = (rm > AW'(32'h7fffffff)) ? 32'h7fffffff : rm[31:0];
  endfunction
  function automatic logic [F-1:0] dsat(input logic [EW-1:0] d);
    dsat = d[F] ? {F{1'b1}} : d[F-1:0];
  endfunction
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= a_vld_r;
    out_block_index <= a_pass_r[PW-1:4];
    out_zero_ray    <= a_pass_r[3];
    out_p_xx <= dsat(a_ent_r[0]);
    out_p_yy <= dsat(a_ent_r[1]);
    out_p_zz <= dsat(a_ent_r[2]);
    out_p_xy <= a_ent_r[3][F:0];
    out_p_xz <= a_ent_r[4][F:0];
    out_p_yz <= a_ent_r[5][F:0];
    out_rhs_x <= rnd_sat(a_sum_r[0]);
    out_rhs_y <= rnd_sat(a_sum_r[1]);
    out_rhs_z <= rnd_sat(a_sum_r[2]);
  end
endmodule : ray_orthogonal_projector_top
`default_nettype wire

// ===== hw/rtl/rop_checker.sv =====
// Port-level checker for the ray orthogonal projector, bound to the top level.
`default_nettype none
module rop_checker import rop_pkg::*; #(
  parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic                       out_zero_ray,
  input wire logic [ENTRY_FRAC_BITS-1:0] out_p_xx,
  input wire logic [ENTRY_FRAC_BITS:0]   out_p_xy,
  input wire logic                       pready
);
  localparam int LAT = ENTRY_FRAC_BITS + 6;

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after a beat");
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_ray) |-> (out_p_xy == '0 && out_p_xx == '1))
    else $error("zero ray not identity");
  a_no_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");
endmodule : rop_checker

bind ray_orthogonal_projector_top rop_checker #(.ENTRY_FRAC_BITS(ENTRY_FRAC_BITS)) u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_zero_ray, .out_p_xx, .out_p_xy, .pready
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the ray orthogonal projector: APB origin setup, random rays.
`default_nettype none
module testbench import rop_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // A register address that decodes to nothing; writes there must be ignored.
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_UNMAPPED = 4'hC;
  localparam int FRAC = ENTRY_FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 << FRAC;
  // The pipeline is ENTRY_FRAC_BITS + 6 deep; allow some margin on top.
  localparam int DRAIN_CYCLES = FRAC + 15;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [15:0]        idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } ray_t;

  typedef struct {
    logic [15:0]        block_index;
    logic [14:0]        p_xx;
    logic signed [15:0] p_xy;
    logic signed [15:0] p_xz;
    logic [14:0]        p_yy;
    logic signed [15:0] p_yz;
    logic [14:0]        p_zz;
    logic signed [31:0] rhs_x;
    logic signed [31:0] rhs_y;
    logic signed [31:0] rhs_z;
    logic               zero_ray;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_point_index = '0;
  logic signed [15:0] in_ray_x = '0, in_ray_y = '0, in_ray_z = '0;
  logic out_valid;
  logic [15:0] out_block_index;
  logic [14:0] out_p_xx, out_p_yy, out_p_zz;
  logic signed [15:0] out_p_xy, out_p_xz, out_p_yz;
  logic signed [31:0] out_rhs_x, out_rhs_y, out_rhs_z;
  logic out_zero_ray;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  ray_orthogonal_projector_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_index(in_point_index), .in_ray_x(in_ray_x), .in_ray_y(in_ray_y),
    .in_ray_z(in_ray_z), .out_valid(out_valid), .out_block_index(out_block_index),
    .out_p_xx(out_p_xx), .out_p_xy(out_p_xy), .out_p_xz(out_p_xz),
    .out_p_yy(out_p_yy), .out_p_yz(out_p_yz), .out_p_zz(out_p_zz),
    .out_rhs_x(out_rhs_x), .out_rhs_y(out_rhs_y), .out_rhs_z(out_rhs_z),
    .out_zero_ray(out_zero_ray), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Our own copy of the camera origin, updated when an APB write lands.
  logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;

  ray_t  ray_queue[$];       // rays waiting for the driver
  proj_t projection_queue[$]; // predicted results, oldest first
  bit    no_gaps;            // when set, the driver sends back to back
  int    errors = 0;
  int    cycles = 0;

  // Rounded |a*b| * 2^FRAC / s, half up; the magnitudes keep num <= s.
  function automatic longint scaled_quotient(longint num, longint s);
    return ((num << (FRAC + 1)) + s) / (2 * s);
  endfunction

  // Sign applied after rounding, so the off-diagonal rounds half away from zero.
  function automatic longint off_diag(longint a, longint b, longint s);
    longint q;
    q = scaled_quotient((a < 0 ? -a : a) * (b < 0 ? -b : b), s);
    return ((a < 0) != (b < 0)) ? q : -q;
  endfunction

  // One row of P*c back in Q16.16, rounded half away from zero, then clamped.
  function automatic logic signed [31:0] origin_row(longint p0, longint p1, longint p2);
    longint acc, m;
    acc = p0 * longint'(origin_x) + p1 * longint'(origin_y) + p2 * longint'(origin_z);
    m = acc < 0 ? -acc : acc;
    m = (m + (64'sd1 << (FRAC - 1))) >>> FRAC;
    if (acc < 0) return (m > 64'sd2147483648) ? 32'sh8000_0000 : 32'(-m);
    return (m > 64'sd2147483647) ? 32'sh7fff_ffff : 32'(m);
  endfunction

  function automatic proj_t project_ray(ray_t r);
    proj_t  p;
    longint x, y, z, s, dxx, dyy, dzz, oxy, oxz, oyz;
    x = r.x; y = r.y; z = r.z;
    s = x * x + y * y + z * z;
    dxx = ONE; dyy = ONE; dzz = ONE; oxy = 0; oxz = 0; oyz = 0;
    if (s != 0) begin
      dxx = ONE - scaled_quotient(x * x, s);
      dyy = ONE - scaled_quotient(y * y, s);
      dzz = ONE - scaled_quotient(z * z, s);
      oxy = off_diag(x, y, s);
      oxz = off_diag(x, z, s);
      oyz = off_diag(y, z, s);
    end
    p.block_index = r.idx;
    // A diagonal of exactly one does not fit the unsigned entry and clamps.
    p.p_xx = (dxx >= ONE) ? '1 : 15'(dxx);
    p.p_yy = (dyy >= ONE) ? '1 : 15'(dyy);
    p.p_zz = (dzz >= ONE) ? '1 : 15'(dzz);
    p.p_xy = 16'(oxy);
    p.p_xz = 16'(oxz);
    p.p_yz = 16'(oyz);
    // The right-hand side uses the unclamped entries.
    p.rhs_x = origin_row(dxx, oxy, oxz);
    p.rhs_y = origin_row(oxy, dyy, oyz);
    p.rhs_z = origin_row(oxz, oyz, dzz);
    p.zero_ray = (s == 0);
    return p;
  endfunction

  // Driver: a beat is taken at an edge where start is high and busy is low.
  // The next ray, or an idle gap, is chosen at that same edge.
  int gap_left = 0;
  always @(posedge clk) begin
    ray_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) projection_queue.insert(projection_queue.size(),
                                         project_ray('{in_point_index, in_ray_x,
                                                       in_ray_y, in_ray_z}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (ray_queue.size() > 0) begin
        r = ray_queue.pop_front();
        in_point_index <= r.idx;
        in_ray_x <= r.x;
        in_ray_y <= r.y;
        in_ray_z <= r.z;
        start <= 1'b1;
        gap_left <= no_gaps ? 0 : $urandom_range(0, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: each out_valid strobe is one result beat, checked against the
  // oldest prediction.
  always @(posedge clk) begin
    proj_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (projection_queue.size() == 0) begin
        $error("result beat with no prediction pending (block_index %0d)",
               out_block_index);
        errors++;
      end else begin
        e = projection_queue.pop_front();
        check_field("block_index", e.block_index, out_block_index);
        check_field("p_xx", e.p_xx, out_p_xx);
        check_field("p_xy", e.p_xy, out_p_xy);
        check_field("p_xz", e.p_xz, out_p_xz);
        check_field("p_yy", e.p_yy, out_p_yy);
        check_field("p_yz", e.p_yz, out_p_yz);
        check_field("p_zz", e.p_zz, out_p_zz);
        check_field("rhs_x", e.rhs_x, out_rhs_x);
        check_field("rhs_y", e.rhs_y, out_rhs_y);
        check_field("rhs_z", e.rhs_z, out_rhs_z);
        check_field("zero_ray", e.zero_ray, out_zero_ray);
      end
    end
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // APB write: setup cycle, then an access cycle; it lands when pready is high.
  task automatic apb_write(logic [CFG_ADDR_BITS-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      ADDR_ORIGIN_X: origin_x = data;
      ADDR_ORIGIN_Y: origin_y = data;
      ADDR_ORIGIN_Z: origin_z = data;
      default: ;
    endcase
  endtask

  task automatic set_origin(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    apb_write(ADDR_ORIGIN_X, cx);
    apb_write(ADDR_ORIGIN_Y, cy);
    apb_write(ADDR_ORIGIN_Z, cz);
  endtask

  task automatic send_ray(int idx, int x, int y, int z);
    ray_queue.insert(ray_queue.size(), '{16'(idx), 16'(x), 16'(y), 16'(z)});
  endtask

  // Random component: the full range, a small value, a bound, or zero.
  function automatic int pick_component();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(0, 1) ? 32767 : -32768;
      2, 3:    return int'($urandom_range(0, 32)) - 16;
      default: return int'(16'($urandom));
    endcase
  endfunction

  // Let every queued ray go out and every prediction be matched, then
  // allow the pipeline to settle before touching the registers.
  task automatic drain();
    wait (ray_queue.size() == 0 && !start && projection_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph, n;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A write to an unmapped address must leave all origins untouched.
    apb_write(ADDR_UNMAPPED, 32'hdead_beef);
    set_origin(32'h0001_8000, 32'hfffe_4000, 32'h0003_0000);

    // Directed rays: zero ray, single axes (diagonal of one), extremes, ties.
    send_ray(0, 0, 0, 0);
    send_ray(65535, 32767, 0, 0);
    send_ray(1, -32768, 0, 0);
    send_ray(2, 0, 32767, 0);
    send_ray(3, 0, -32768, 0);
    send_ray(4, 0, 0, 32767);
    send_ray(5, 0, 0, -32768);
    send_ray(6, -32768, -32768, -32768);
    send_ray(7, 32767, 32767, 32767);
    send_ray(8, 32767, -32768, 32767);
    send_ray(9, -32768, 32767, -32768);
    send_ray(10, 1, 1, 0);
    send_ray(11, 1, -1, 1);
    send_ray(12, -1, 1, -1);
    send_ray(13, 1, 2, 3);
    send_ray(14, 3, 4, 0);
    send_ray(15, 0, -5, 12);
    send_ray(16, 1, 0, 0);
    send_ray(17, 0, 0, -1);
    send_ray(32768, 32767, -1, 0);
    drain();

    // Six origin settings, the extremes among them; one phase runs without
    // gaps so the pipeline is kept full.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_origin(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        1: set_origin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        2: set_origin(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        3: set_origin(32'h0, 32'h0, 32'h0);
        default: set_origin($urandom, $urandom, $urandom);
      endcase
      no_gaps = (ph == 2);
      for (n = 0; n < 200; n++)
        send_ray($urandom_range(0, 65535), pick_component(), pick_component(),
                 pick_component());
      // The sender holds off here until every result of the phase is back.
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
